// ----- design/protobuf_field_tokenizer_assert.svh -----
// Assertion macros shared by the protobuf field tokenizer modules.
// Needs nothing but a clock and a reset signal at each point of use.
`ifndef PROTOBUF_FIELD_TOKENIZER_ASSERT_SVH
`define PROTOBUF_FIELD_TOKENIZER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PFT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define PFT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PFT_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define PFT_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define PFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- design/pft_pkg.sv -----
// Shared types and codes for the protobuf field tokenizer.
// Used by pft_core, pft_skid and protobuf_field_tokenizer; depends on nothing.
`timescale 1ns / 1ps
package pft_pkg;

  // Input item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Result kinds.
  localparam logic [2:0] RK_VARINT     = 3'd0;
  localparam logic [2:0] RK_FIXED_HDR  = 3'd1;
  localparam logic [2:0] RK_LEN_HDR    = 3'd2;
  localparam logic [2:0] RK_VALUE_BYTE = 3'd3;
  localparam logic [2:0] RK_BUF_END    = 3'd4;

  // Buffer end status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;
  localparam logic [1:0] ST_BAD_WIRE  = 2'd3;

  // Wire types handled by the tokenizer.
  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LEN     = 3'd2;

  localparam logic [63:0] FIXED64_BYTES    = 64'd8;
  localparam logic [3:0]  MAX_VARINT_BYTES = 4'd10;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] field_number;
    logic [2:0]  wire_code;
    logic [63:0] value;
    logic [7:0]  value_byte;
    logic        field_end;
    logic [1:0]  status;
  } pft_result_t;

endpackage

// ----- design/pft_core.sv -----
// Tokenizer state machine: varint assembly, field tracking and error status.
// Depends on pft_pkg and the assertion header.
`timescale 1ns / 1ps
`include "protobuf_field_tokenizer_assert.svh"
module pft_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 kind,
  input  logic [7:0]           data_byte,
  output logic                 push,
  output pft_pkg::pft_result_t res
);
  import pft_pkg::*;

  typedef enum logic [2:0] {
    PH_TAG, PH_VARINT, PH_LEN, PH_FIXED, PH_PAYLOAD, PH_ERROR
  } phase_t;

  phase_t      phase, phase_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  cnt, cnt_next;
  logic [31:0] cur_field, cur_field_next;
  logic [2:0]  cur_wire, cur_wire_next;
  logic [63:0] remaining, remaining_next;
  logic [1:0]  err, err_next;

  logic [5:0]  shamt;
  logic [63:0] acc_or;
  logic [3:0]  cnt_inc;
  logic [63:0] rem_dec;
  logic [1:0]  end_status;

  assign shamt   = 6'({2'b00, cnt} * 6'd7);
  assign acc_or  = acc | ({57'd0, data_byte[6:0]} << shamt);
  assign cnt_inc = cnt + 4'd1;
  assign rem_dec = remaining - 64'd1;

  always_comb begin
    phase_next     = phase;
    acc_next       = acc;
    cnt_next       = cnt;
    cur_field_next = cur_field;
    cur_wire_next  = cur_wire;
    remaining_next = remaining;
    err_next       = err;
    push           = 1'b0;
    res            = '0;
    end_status     = err;
    if (accept) begin
      if (kind == KIND_END) begin
        if (err == ST_OK && (phase != PH_TAG || cnt != 4'd0)) begin
          end_status = ST_TRUNCATED;
        end
        phase_next     = PH_TAG;
        acc_next       = '0;
        cnt_next       = '0;
        cur_field_next = '0;
        cur_wire_next  = '0;
        remaining_next = '0;
        err_next       = ST_OK;
        push           = 1'b1;
        res.result_kind = RK_BUF_END;
        res.status      = end_status;
      end else begin
        unique case (phase)
          PH_FIXED, PH_PAYLOAD: begin
            remaining_next   = rem_dec;
            push             = 1'b1;
            res.result_kind  = RK_VALUE_BYTE;
            res.field_number = cur_field;
            res.wire_code    = cur_wire;
            res.value_byte   = data_byte;
            res.field_end    = (rem_dec == 64'd0);
            if (rem_dec == 64'd0) begin
              phase_next = PH_TAG;
            end
          end
          PH_TAG, PH_VARINT, PH_LEN: begin
            if (data_byte[7]) begin
              acc_next = acc_or;
              cnt_next = cnt_inc;
              if (cnt_inc >= MAX_VARINT_BYTES) begin
                err_next   = ST_TOO_LONG;
                phase_next = PH_ERROR;
              end
            end else begin
              acc_next = '0;
              cnt_next = '0;
              if (phase == PH_TAG) begin
                cur_field_next = acc_or[34:3];
                cur_wire_next  = acc_or[2:0];
                case (acc_or[2:0])
                  WIRE_VARINT: phase_next = PH_VARINT;
                  WIRE_FIXED64: begin
                    remaining_next   = FIXED64_BYTES;
                    phase_next       = PH_FIXED;
                    push             = 1'b1;
                    res.result_kind  = RK_FIXED_HDR;
                    res.field_number = acc_or[34:3];
                    res.wire_code    = acc_or[2:0];
                    res.value        = FIXED64_BYTES;
                  end
                  WIRE_LEN: phase_next = PH_LEN;
                  default: begin
                    err_next   = ST_BAD_WIRE;
                    phase_next = PH_ERROR;
                  end
                endcase
              end else if (phase == PH_VARINT) begin
                phase_next       = PH_TAG;
                push             = 1'b1;
                res.result_kind  = RK_VARINT;
                res.field_number = cur_field;
                res.wire_code    = cur_wire;
                res.value        = acc_or;
                res.field_end    = 1'b1;
              end else begin
                remaining_next   = acc_or;
                phase_next       = (acc_or == 64'd0) ? PH_TAG : PH_PAYLOAD;
                push             = 1'b1;
                res.result_kind  = RK_LEN_HDR;
                res.field_number = cur_field;
                res.wire_code    = cur_wire;
                res.value        = acc_or;
                res.field_end    = (acc_or == 64'd0);
              end
            end
          end
          PH_ERROR: begin
            // Bytes after an error are dropped until the buffer ends.
          end
          default: begin
            phase_next = PH_ERROR;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TAG;
      acc       <= '0;
      cnt       <= '0;
      cur_field <= '0;
      cur_wire  <= '0;
      remaining <= '0;
      err       <= ST_OK;
    end else begin
      phase     <= phase_next;
      acc       <= acc_next;
      cnt       <= cnt_next;
      cur_field <= cur_field_next;
      cur_wire  <= cur_wire_next;
      remaining <= remaining_next;
      err       <= err_next;
    end
  end

  `PFT_ASSERT_IMPL(a_push_needs_accept, clk, rst, push, accept, "result without transfer")
  `PFT_ASSERT_IMPL(a_error_has_status, clk, rst, phase == PH_ERROR, err != ST_OK,
                   "error phase with clean status")
  `PFT_ASSERT_IMPL(a_count_bound, clk, rst, phase != PH_ERROR, cnt <= 4'd9,
                   "varint byte count out of range")
  `PFT_ASSERT_NEXT(a_end_resets, clk, rst, accept && kind == KIND_END,
                   phase == PH_TAG && cnt == 4'd0 && err == ST_OK,
                   "buffer end did not restore idle state")

endmodule

// ----- design/pft_skid.sv -----
// Two-entry output buffer that decouples the tokenizer from result stalls.
// Depends on pft_pkg and the assertion header.
`timescale 1ns / 1ps
`include "protobuf_field_tokenizer_assert.svh"
module pft_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pft_pkg::pft_result_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pft_pkg::pft_result_t head
);
  import pft_pkg::*;

  pft_result_t tail;
  logic [1:0]  count;
  logic        pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case (count)
        2'd0: begin
          if (push) begin
            head  <= push_data;
            count <= 2'd1;
          end
        end
        2'd1: begin
          if (pop && push) begin
            head <= push_data;
          end else if (pop) begin
            count <= 2'd0;
          end else if (push) begin
            tail  <= push_data;
            count <= 2'd2;
          end
        end
        default: begin
          if (pop) begin
            head  <= tail;
            count <= 2'd1;
          end
        end
      endcase
    end
  end

  `PFT_ASSERT_ALWAYS(a_count_range, clk, rst, count != 2'd3, "buffer count out of range")
  `PFT_ASSERT_IMPL(a_no_push_full, clk, rst, push, !full, "push into full buffer")
  `PFT_ASSERT_NEXT(a_tail_moves, clk, rst, full && pop, head == $past(tail),
                   "waiting result lost on drain")

endmodule

// ----- design/protobuf_field_tokenizer.sv -----
// A result is registered into the output buffer and shows on the outputs when any
// result ahead of it is taken. Throughput: one input item per cycle; the tokenizer
// state is updated by a single combinational pass; a two-entry output buffer absorbs
// result stalls, so input stalls only when two results wait. Reset is synchronous
// and active high: it returns the parser to tag reading and empties the buffer.
`timescale 1ns / 1ps
// Top level of the protobuf field tokenizer.
// Depends on pft_pkg, pft_core and pft_skid.
module protobuf_field_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  result_kind,
  output logic [31:0] field_number,
  output logic [2:0]  wire_code,
  output logic [63:0] value,
  output logic [7:0]  value_byte,
  output logic        field_end,
  output logic [1:0]  status
);
  import pft_pkg::*;

  logic        accept;
  logic        push;
  logic        full;
  pft_result_t res;
  pft_result_t head;

  // Every input transfer produces at most one result, so the input only has to
  // wait when both buffer entries are taken. Bytes that produce no result still
  // need a free entry, which keeps the stall a plain registered flag.
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  // The core holds the parse state: the current phase, the varint being built,
  // the field number and wire type of the open field, the count of value bytes
  // still owed, and the first error seen in this buffer.
  pft_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (kind),
    .data_byte (data_byte),
    .push      (push),
    .res       (res)
  );

  // The result register and its skid entry.
  pft_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign result_kind  = head.result_kind;
  assign field_number = head.field_number;
  assign wire_code    = head.wire_code;
  assign value        = head.value;
  assign value_byte   = head.value_byte;
  assign field_end    = head.field_end;
  assign status       = head.status;

endmodule
